>>> hdl/htwd_pkg.sv
// Shared types and constants for the Huffman tree-walk decoder.
// Used by htwd_node_store, htwd_walker and huffman_tree_walk_decoder.
package htwd_pkg;

   localparam int NODE_W = 9;
   localparam int SYM_W = 8;
   localparam int FUNC_W = 2;
   localparam int BITS_W = 4;
   localparam int BYTE_BITS = 8;

   localparam logic [FUNC_W-1:0] FUNC_LOAD_CHILDREN = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_LEAF = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_DECODE = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_LOOK,
      ST_DECIDE,
      ST_FLUSH
   } walk_state_type;

   // Writes and the read address sent to the node store each cycle.
   typedef struct packed {
      logic              wr_child;
      logic              wr_leaf;
      logic [NODE_W-1:0] wr_node;
      logic [NODE_W-1:0] left;
      logic [NODE_W-1:0] right;
      logic [SYM_W-1:0]  sym;
      logic [NODE_W-1:0] rd_node;
   } store_req_type;

   // Registered read data of the node addressed in the cycle before.
   typedef struct packed {
      logic              is_leaf;
      logic [NODE_W-1:0] left;
      logic [NODE_W-1:0] right;
      logic [SYM_W-1:0]  sym;
   } store_rsp_type;

   // One decoded symbol handed to the output register.
   typedef struct packed {
      logic             valid;
      logic [SYM_W-1:0] sym;
      logic             run_last;
      logic             stream_end;
   } sym_push_type;

endpackage

>>> hdl/htwd_node_store.sv
// Node tables of the code tree: child pairs, leaf flags and leaf symbols.
// Depends on htwd_pkg. Leaf flags are set to one by a sweep after reset.
module htwd_node_store import htwd_pkg::*; #(
   parameter int TREE_NODES = 512
) (
   input  logic          clock,
   input  logic          reset,
   input  store_req_type req,
   output store_rsp_type rsp,
   output logic          busy
);

   localparam int ADDR_W = $clog2(TREE_NODES);

   logic [2*NODE_W-1:0] child_mem [TREE_NODES];
   logic                leaf_mem [TREE_NODES];
   logic [SYM_W-1:0]    sym_mem [TREE_NODES];

   logic [2*NODE_W-1:0] child_rd_ff;
   logic                leaf_rd_ff;
   logic [SYM_W-1:0]    sym_rd_ff;
   logic                in_range_rd_ff;

   logic              clearing_ff, clearing_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   logic              wr_in_range;
   logic              rd_in_range;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;

   assign wr_in_range = int'(req.wr_node) < TREE_NODES;
   assign rd_in_range = int'(req.rd_node) < TREE_NODES;
   assign wr_addr = ADDR_W'(req.wr_node);
   assign rd_addr = ADDR_W'(req.rd_node);

   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(TREE_NODES - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.wr_child && wr_in_range) begin
         child_mem[wr_addr] <= {req.right, req.left};
      end
      child_rd_ff <= child_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (req.wr_leaf && wr_in_range) begin
         sym_mem[wr_addr] <= req.sym;
      end
      sym_rd_ff <= sym_mem[rd_addr];
   end

   // Sweep marks every node a leaf; loads are held off until it ends.
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         leaf_mem[clr_addr_ff] <= 1'b1;
      end else if ((req.wr_child || req.wr_leaf) && wr_in_range) begin
         leaf_mem[wr_addr] <= req.wr_leaf;
      end
      leaf_rd_ff <= leaf_mem[rd_addr];
      in_range_rd_ff <= rd_in_range;
   end

   // Nodes past the table read as leaves with symbol zero.
   always_comb begin
      rsp.is_leaf = leaf_rd_ff || !in_range_rd_ff;
      rsp.left = child_rd_ff[NODE_W-1:0];
      rsp.right = child_rd_ff[2*NODE_W-1:NODE_W];
      rsp.sym = in_range_rd_ff ? sym_rd_ff : '0;
   end

   assign busy = clearing_ff;

endmodule

>>> hdl/htwd_walker.sv
// Walk sequencer: takes input words, issues node store reads one bit at a
// time and passes decoded symbols on. Depends on htwd_pkg.
module htwd_walker import htwd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [FUNC_W-1:0] req_func,
   input  logic [NODE_W-1:0] req_node_index,
   input  logic [NODE_W-1:0] req_left_child,
   input  logic [NODE_W-1:0] req_right_child,
   input  logic [SYM_W-1:0]  req_leaf_symbol,
   input  logic [SYM_W-1:0]  req_data_byte,
   input  logic              req_final_byte,
   input  logic [BITS_W-1:0] req_valid_bits,
   input  logic              csr_wr_en,
   input  logic [NODE_W-1:0] csr_wr_data,
   input  logic              store_busy,
   input  store_rsp_type     store_rsp,
   output store_req_type     store_req,
   input  logic              push_ok,
   output sym_push_type      push
);

   walk_state_type state_ff, state_in;

   logic [NODE_W-1:0] root_ff, root_in;
   logic [NODE_W-1:0] walk_ff, walk_in;
   logic [NODE_W-1:0] next_ff, next_in;
   logic [SYM_W-1:0]  data_ff, data_in;
   logic              fin_ff, fin_in;
   logic [BITS_W-1:0] bits_ff, bits_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [SYM_W-1:0]  pend_sym_ff, pend_sym_in;
   logic              pend_end_ff, pend_end_in;

   logic              accept;
   logic              is_decode;
   logic [BITS_W-1:0] req_nbits;
   logic              cur_bit;
   logic [NODE_W-1:0] look_next;
   logic              emit_stall;
   logic              flush_stall;
   logic              last_bit;

   assign req_ready = (state_ff == ST_IDLE) && !store_busy;
   assign accept = req_valid && req_ready;
   assign is_decode = req_func == FUNC_DECODE;

   // Final bytes carry at most a full byte of code bits.
   always_comb begin
      if (!req_final_byte) begin
         req_nbits = BITS_W'(BYTE_BITS);
      end else if (req_valid_bits > BITS_W'(BYTE_BITS)) begin
         req_nbits = BITS_W'(BYTE_BITS);
      end else begin
         req_nbits = req_valid_bits;
      end
   end

   assign cur_bit = data_ff[3'(bits_ff - 1'b1)];
   assign look_next = store_rsp.is_leaf ? walk_ff :
                      (cur_bit ? store_rsp.right : store_rsp.left);
   assign emit_stall = store_rsp.is_leaf && pend_valid_ff && !push_ok;
   assign flush_stall = pend_valid_ff && !push_ok;
   assign last_bit = bits_ff == BITS_W'(1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && is_decode && req_nbits != '0) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: state_in = ST_LOOK;
         ST_LOOK: state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (!emit_stall) begin
               if (last_bit) begin
                  state_in = ST_FLUSH;
               end else if (store_rsp.is_leaf) begin
                  state_in = ST_FETCH;
               end else begin
                  state_in = ST_LOOK;
               end
            end
         end
         ST_FLUSH: begin
            if (!flush_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      root_in = root_ff;
      walk_in = walk_ff;
      next_in = next_ff;
      data_in = data_ff;
      fin_in = fin_ff;
      bits_in = bits_ff;
      pend_valid_in = pend_valid_ff;
      pend_sym_in = pend_sym_ff;
      pend_end_in = pend_end_ff;

      store_req.wr_child = 1'b0;
      store_req.wr_leaf = 1'b0;
      store_req.wr_node = req_node_index;
      store_req.left = req_left_child;
      store_req.right = req_right_child;
      store_req.sym = req_leaf_symbol;
      store_req.rd_node = walk_ff;

      push.valid = 1'b0;
      push.sym = pend_sym_ff;
      push.run_last = 1'b0;
      push.stream_end = pend_end_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (csr_wr_en) begin
               root_in = csr_wr_data;
               walk_in = csr_wr_data;
            end
            if (accept) begin
               store_req.wr_child = req_func == FUNC_LOAD_CHILDREN;
               store_req.wr_leaf = req_func == FUNC_LOAD_LEAF;
               if (is_decode) begin
                  data_in = req_data_byte;
                  fin_in = req_final_byte;
                  bits_in = req_nbits;
                  if (req_nbits == '0 && req_final_byte) begin
                     walk_in = root_ff;
                  end
               end
            end
         end
         ST_FETCH: begin
            store_req.rd_node = walk_ff;
         end
         ST_LOOK: begin
            store_req.rd_node = look_next;
            next_in = look_next;
         end
         ST_DECIDE: begin
            // Hold the read address so the data stays put during a stall.
            store_req.rd_node = next_ff;
            if (!emit_stall) begin
               bits_in = bits_ff - 1'b1;
               if (store_rsp.is_leaf) begin
                  push.valid = pend_valid_ff;
                  pend_valid_in = 1'b1;
                  pend_sym_in = store_rsp.sym;
                  pend_end_in = fin_ff && last_bit;
                  walk_in = root_ff;
               end else begin
                  walk_in = next_ff;
               end
            end
         end
         ST_FLUSH: begin
            if (!flush_stall) begin
               push.valid = pend_valid_ff;
               push.run_last = 1'b1;
               pend_valid_in = 1'b0;
               if (fin_ff) begin
                  walk_in = root_ff;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         root_ff <= '0;
         walk_ff <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         root_ff <= root_in;
         walk_ff <= walk_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      next_ff <= next_in;
      data_ff <= data_in;
      fin_ff <= fin_in;
      bits_ff <= bits_in;
      pend_sym_ff <= pend_sym_in;
      pend_end_ff <= pend_end_in;
   end

endmodule

>>> hdl/huffman_tree_walk_decoder.sv
// Huffman tree-walk decoder top level: walker, node store, output register.
// Depends on htwd_pkg, htwd_node_store and htwd_walker.
//
// Load words (children or leaf symbol) are written to the node store as
// they are taken, and the block stays ready for the next one. A data word
// walks the stored tree one code bit at a time through the single read port
// of the node store: each bit needs two dependent reads (the current node's
// children, then the reached node's leaf flag and symbol), so a bit passes
// LOOK and DECIDE while the walk stays on internal nodes, and FETCH, LOOK
// and DECIDE for the first bit and the bit after a leaf, when the root is
// fetched again. A word is taken in IDLE, its last symbol leaves in FLUSH,
// and the walk waits while the receiver holds the output register. Each
// symbol is held back one step so the last of a word can carry run_last.
// After reset it marks every node a leaf, taking root writes but no word.
module huffman_tree_walk_decoder import htwd_pkg::*; #(
   parameter int TREE_NODES = 512
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [FUNC_W-1:0] req_func,
   input  logic [NODE_W-1:0] req_node_index,
   input  logic [NODE_W-1:0] req_left_child,
   input  logic [NODE_W-1:0] req_right_child,
   input  logic [SYM_W-1:0]  req_leaf_symbol,
   input  logic [SYM_W-1:0]  req_data_byte,
   input  logic              req_final_byte,
   input  logic [BITS_W-1:0] req_valid_bits,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [SYM_W-1:0]  rsp_symbol,
   output logic              rsp_run_last,
   output logic              rsp_stream_end,
   input  logic              csr_wr_en,
   input  logic [NODE_W-1:0] csr_wr_data
);

   store_req_type store_req;
   store_rsp_type store_rsp;
   sym_push_type  push;
   logic          store_busy;
   logic          push_ok;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [SYM_W-1:0] rsp_symbol_ff, rsp_symbol_in;
   logic             rsp_run_last_ff, rsp_run_last_in;
   logic             rsp_stream_end_ff, rsp_stream_end_in;

   htwd_node_store #(
      .TREE_NODES(TREE_NODES)
   ) u_store (
      .clock(clock),
      .reset(reset),
      .req(store_req),
      .rsp(store_rsp),
      .busy(store_busy)
   );

   htwd_walker u_walker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_func),
      .req_node_index(req_node_index),
      .req_left_child(req_left_child),
      .req_right_child(req_right_child),
      .req_leaf_symbol(req_leaf_symbol),
      .req_data_byte(req_data_byte),
      .req_final_byte(req_final_byte),
      .req_valid_bits(req_valid_bits),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .store_busy(store_busy),
      .store_rsp(store_rsp),
      .store_req(store_req),
      .push_ok(push_ok),
      .push(push)
   );

   assign push_ok = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_run_last_in = rsp_run_last_ff;
      rsp_stream_end_in = rsp_stream_end_ff;
      if (push.valid) begin
         rsp_valid_in = 1'b1;
         rsp_symbol_in = push.sym;
         rsp_run_last_in = push.run_last;
         rsp_stream_end_in = push.stream_end;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_run_last_ff <= rsp_run_last_in;
      rsp_stream_end_ff <= rsp_stream_end_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_symbol = rsp_symbol_ff;
   assign rsp_run_last = rsp_run_last_ff;
   assign rsp_stream_end = rsp_stream_end_ff;

endmodule
